FILE: hw/rtl/dnle_pkg.sv
// Package for the DNS name label encoder: item types, controller state,
// command and status structs, and sizing constants. Depends on nothing.
package dnle_pkg;

   // Label store sizing.
   localparam int STORE_DEPTH   = 63;
   localparam int STORE_AW      = $clog2(STORE_DEPTH);
   localparam int COUNT_W       = 6;
   localparam int LABEL_MAX_DEF = 63;

   // Character that separates labels.
   localparam logic [7:0] DOT_CHAR = 8'h2E;

   // One input item: a name character or an end-of-name mark.
   typedef struct packed {
      logic [7:0] ch;
      logic       end_of_name;
   } req_item_type;

   // One result item: a byte of the encoded label.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       overflow;
   } rsp_item_type;

   // Controller states.
   typedef enum logic {
      ST_IDLE,
      ST_SEND
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic store_char;
      logic close_label;
      logic send_byte;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_close;
      logic len_zero;
      logic last_byte;
      logic out_free;
   } stat_type;

endpackage

FILE: hw/rtl/dnle_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module dnle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 63,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port; read data holds between reads.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/dnle_ctrl.sv
// Controller state machine for the DNS name label encoder.
// Depends on dnle_pkg.
module dnle_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  dnle_pkg::stat_type stat,
   output dnle_pkg::cmd_type  cmd
);
   import dnle_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            // Items are taken whenever the output register can take a byte.
            req_stall = !stat.out_free;
            if (req_valid && stat.out_free) begin
               if (stat.is_close) begin
                  cmd.close_label = 1'b1;
                  if (!stat.len_zero) begin
                     state_in = ST_SEND;
                  end
               end else begin
                  cmd.store_char = 1'b1;
               end
            end
         end
         ST_SEND: begin
            // Replay the buffered characters, one per free output slot.
            if (stat.out_free) begin
               cmd.send_byte = 1'b1;
               if (stat.last_byte) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: hw/rtl/dnle_dp.sv
// Datapath for the DNS name label encoder: label store, counters and the
// output register. Depends on dnle_pkg and dnle_ram.
module dnle_dp #(
   parameter int LABEL_MAX = dnle_pkg::LABEL_MAX_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dnle_pkg::req_item_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output dnle_pkg::rsp_item_type rsp_data,
   input  dnle_pkg::cmd_type      cmd,
   output dnle_pkg::stat_type     stat
);
   import dnle_pkg::*;

   localparam logic [COUNT_W-1:0] LimitC = COUNT_W'(LABEL_MAX);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic               ovf_ff, ovf_in;
   logic [COUNT_W-1:0] len_ff, len_in;
   logic [COUNT_W-1:0] idx_ff, idx_in;
   logic               lab_ov_ff, lab_ov_in;
   rsp_item_type       rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               wr_en;
   logic               rd_en;
   logic [STORE_AW-1:0] rd_addr;
   logic [7:0]          rd_data;
   logic                last_byte;

   dnle_ram #(
      .WIDTH (8),
      .DEPTH (STORE_DEPTH),
      .AW    (STORE_AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (STORE_AW'(count_ff)),
      .wr_data (req_data.ch),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Status toward the controller.
   assign last_byte      = (idx_ff == len_ff - COUNT_W'(1));
   assign stat.is_close  = req_data.end_of_name || (req_data.ch == DOT_CHAR);
   assign stat.len_zero  = (count_ff == '0);
   assign stat.last_byte = last_byte;
   assign stat.out_free  = !rsp_valid_ff || !rsp_stall;

   // A character is stored while the label has room; otherwise it is dropped.
   assign wr_en = cmd.store_char && (count_ff < LimitC);

   // Closing a non-empty label reads the first character; each sent byte but the last reads the next one.
   assign rd_en   = (cmd.close_label && !stat.len_zero) || (cmd.send_byte && !last_byte);
   assign rd_addr = cmd.send_byte ? STORE_AW'(idx_ff + COUNT_W'(1)) : '0;

   // Next values of the label state and the output register.
   always_comb begin
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      len_in       = len_ff;
      idx_in       = idx_ff;
      lab_ov_in    = lab_ov_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.store_char) begin
         if (count_ff < LimitC) begin
            count_in = count_ff + COUNT_W'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (cmd.close_label) begin
         // The length byte goes out first; the label state starts over.
         rsp_in.out_byte    = 8'(count_ff);
         rsp_in.last_of_run = (count_ff == '0);
         rsp_in.overflow    = ovf_ff;
         rsp_valid_in       = 1'b1;
         len_in             = count_ff;
         lab_ov_in          = ovf_ff;
         idx_in             = '0;
         count_in           = '0;
         ovf_in             = 1'b0;
      end
      if (cmd.send_byte) begin
         rsp_in.out_byte    = rd_data;
         rsp_in.last_of_run = last_byte;
         rsp_in.overflow    = lab_ov_ff;
         rsp_valid_in       = 1'b1;
         idx_in             = idx_ff + COUNT_W'(1);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      len_ff    <= len_in;
      idx_ff    <= idx_in;
      lab_ov_ff <= lab_ov_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The held character count never passes the label limit.
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= LimitC)
      else $error("label count above limit");

   // A replayed byte always lies inside the closed label.
   a_idx_in_label : assert property (@(posedge clock) disable iff (reset)
      cmd.send_byte |-> (idx_ff < len_ff))
      else $error("replay index beyond label length");

   // A stored character, a label close and a replayed byte never coincide.
   a_cmd_exclusive : assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.store_char, cmd.close_label, cmd.send_byte}) <= 1)
      else $error("conflicting datapath commands");

endmodule

FILE: hw/rtl/dns_name_label_encoder_unit.sv
// Top level of the DNS name label encoder: joins controller and datapath.
// Depends on dnle_pkg, dnle_ctrl, dnle_dp and dnle_ram.
//
// The unit takes a host name one character item at a time and emits DNS wire
// labels. A character item produces no result; up to LABEL_MAX characters
// are kept per label and later ones are dropped, which sets the overflow
// flag on every byte of that label. A dot or an end-of-name item closes the
// label: its length byte appears on the output in the cycle after the item
// is taken, then the n buffered characters follow at one byte a cycle while
// the output does not stall, paced by the single read port of the label
// store. An empty label gives a single zero byte. The store needs no
// clearing after reset, and output stalls simply hold the replay.
module dns_name_label_encoder_unit #(
   parameter int LABEL_MAX = dnle_pkg::LABEL_MAX_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  dnle_pkg::req_item_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output dnle_pkg::rsp_item_type rsp_data
);
   import dnle_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   dnle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   dnle_dp #(
      .LABEL_MAX (LABEL_MAX)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

FILE: tb/dnle_stream_checker.sv
// Stream checker for the DNS name label encoder: watches both channels,
// predicts the encoded bytes and compares them. Depends on dnle_pkg.
module dnle_stream_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  dnle_pkg::req_item_type req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  dnle_pkg::rsp_item_type rsp_data,
   output int                     mismatch_count,
   output int                     bytes_pending,
   output int                     bytes_checked,
   output int                     labels_closed,
   output int                     overflowed_labels
);
   timeunit 1ns;
   timeprecision 1ps;
   import dnle_pkg::*;

   // The store depth caps the label length when the limit is set above it.
   localparam int LABEL_LIMIT = (LABEL_MAX_DEF > STORE_DEPTH) ? STORE_DEPTH : LABEL_MAX_DEF;

   logic [7:0]         label_chars [STORE_DEPTH];
   logic [COUNT_W-1:0] label_len;
   logic               label_dropped;
   rsp_item_type       expected_bytes [$];

   // Append one byte to the tail of the expected stream.
   task automatic enqueue_expected(input rsp_item_type b);
      expected_bytes = {expected_bytes, b};
   endtask

   // Fold one accepted item into the label state; a closing item queues
   // the length byte and the buffered characters.
   task automatic absorb_name_item(input req_item_type item);
      int           n;
      rsp_item_type b;
      if (!item.end_of_name && item.ch != DOT_CHAR) begin
         if (label_len < LABEL_LIMIT) begin
            label_chars[label_len] = item.ch;
            label_len = label_len + 1'b1;
         end else begin
            label_dropped = 1'b1;
         end
      end else begin
         n = int'(label_len);
         b.out_byte    = 8'(n);
         b.last_of_run = (n == 0);
         b.overflow    = label_dropped;
         enqueue_expected(b);
         for (int k = 0; k < n; k++) begin
            b.out_byte    = label_chars[k];
            b.last_of_run = (k + 1 == n);
            b.overflow    = label_dropped;
            enqueue_expected(b);
         end
         labels_closed++;
         if (label_dropped) begin
            overflowed_labels++;
         end
         label_len     = '0;
         label_dropped = 1'b0;
      end
   endtask

   // Compare one accepted result item against the oldest expected byte.
   task automatic check_byte(input rsp_item_type got);
      rsp_item_type want;
      bytes_checked++;
      if (expected_bytes.size() == 0) begin
         if (mismatch_count < 10) begin
            $display("%0t: unexpected byte %02h last %0b ovf %0b", $realtime,
                     got.out_byte, got.last_of_run, got.overflow);
         end
         mismatch_count++;
      end else begin
         want = expected_bytes.pop_front();
         if (got.out_byte !== want.out_byte || got.last_of_run !== want.last_of_run ||
             got.overflow !== want.overflow) begin
            if (mismatch_count < 10) begin
               $display("%0t: byte mismatch: expected %02h last %0b ovf %0b,",
                        $realtime, want.out_byte, want.last_of_run, want.overflow,
                        " got %02h last %0b ovf %0b",
                        got.out_byte, got.last_of_run, got.overflow);
            end
            mismatch_count++;
         end
      end
   endtask

   // Input items are folded in before the result of the same edge is checked,
   // so the queue always holds every byte the block still owes.
   always @(posedge clock) begin
      if (reset) begin
         label_len     = '0;
         label_dropped = 1'b0;
         expected_bytes.delete();
      end else begin
         if (req_valid && !req_stall) begin
            absorb_name_item(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            check_byte(rsp_data);
         end
      end
      bytes_pending <= expected_bytes.size();
   end

endmodule

FILE: tb/tb_dns_name_label_encoder_unit.sv
// Top of the DNS name label encoder testbench: clock, reset, name stimulus,
// output stalls and the verdict. Depends on dnle_pkg, dnle_stream_checker and the unit.
module tb_dns_name_label_encoder_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import dnle_pkg::*;

   localparam int RUN_LIMIT     = 300000;
   localparam int RANDOM_ITEMS  = 250;
   localparam int LONG_HOLD     = 400;
   localparam int DRAIN_CYCLES  = 80;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_item_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_item_type rsp_data;

   int mismatch_count;
   int bytes_pending;
   int bytes_checked;
   int labels_closed;
   int overflowed_labels;
   int items_sent;
   int cycle_count;
   int holds_wanted;
   bit sender_quiet;

   dns_name_label_encoder_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   dnle_stream_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data          (req_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_data          (rsp_data),
      .mismatch_count    (mismatch_count),
      .bytes_pending     (bytes_pending),
      .bytes_checked     (bytes_checked),
      .labels_closed     (labels_closed),
      .overflowed_labels (overflowed_labels)
   );

   // Free-running clock with a 10 ns period.
   initial begin
      clock = 1'b0;
   end
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: a run that hangs ends as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("dns_name_label_encoder_unit regression: fail");
         $finish;
      end
   end

   // Idle stretch length: mostly short, a few long.
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         return $urandom_range(1, 3);
      end else if (r < 92) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 60);
   endfunction

   // Output side: random stalls, quiet stretches, and long holds on request.
   initial begin
      int stall_left;
      int holds_done;
      bit quiet;
      stall_left = 0;
      holds_done = 0;
      quiet      = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_done < holds_wanted) begin
            holds_done++;
            stall_left = LONG_HOLD;
         end
         if ($urandom_range(0, 199) == 0) begin
            quiet = !quiet;
         end
         if (stall_left == 0 && !quiet && $urandom_range(0, 99) < 25) begin
            stall_left = idle_length();
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Offer one item, after an optional idle gap, and wait until it is taken.
   task automatic send_item(input logic [7:0] ch, input logic end_of_name);
      int gap;
      gap = 0;
      if ($urandom_range(0, 63) == 0) begin
         sender_quiet = !sender_quiet;
      end
      if (!sender_quiet && $urandom_range(0, 99) < 40) begin
         gap = idle_length();
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_data.ch          <= ch;
      req_data.end_of_name <= end_of_name;
      do begin
         @(posedge clock);
      end while (req_stall);
      items_sent++;
   endtask

   // A label character other than the separator, often a lowercase letter.
   function automatic logic [7:0] label_char();
      logic [7:0] c;
      if ($urandom_range(0, 99) < 40) begin
         return 8'($urandom_range(8'h61, 8'h7A));
      end
      do begin
         c = 8'($urandom_range(0, 255));
      end while (c == DOT_CHAR);
      return c;
   endfunction

   // One label of the given length, closed by a dot or by an end-of-name item
   // whose character is random and must be ignored.
   task automatic send_label(input int len, input bit close_with_end);
      for (int i = 0; i < len; i++) begin
         send_item(label_char(), 1'b0);
      end
      if (close_with_end) begin
         send_item(8'($urandom_range(0, 255)), 1'b1);
      end else begin
         send_item(DOT_CHAR, 1'b0);
      end
   endtask

   // Random label length: mostly short, some near or past the label limit.
   function automatic int label_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 72) begin
         return $urandom_range(0, 8);
      end else if (r < 90) begin
         return $urandom_range(9, 30);
      end else if (r < 97) begin
         return $urandom_range(55, LABEL_MAX_DEF);
      end
      return $urandom_range(LABEL_MAX_DEF + 1, LABEL_MAX_DEF + 9);
   endfunction

   // Stop offering and wait until every expected byte has come out.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (bytes_pending != 0);
   endtask

   // Main sequence: reset, directed items, pressure, random names, verdict.
   initial begin
      int random_start;
      int half_done;
      reset                <= 1'b1;
      req_valid            <= 1'b0;
      req_data             <= '0;
      holds_wanted         <= 0;
      items_sent            = 0;
      sender_quiet          = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: one-character label, empty labels closed both ways,
      // byte extremes stored verbatim, and a trailing dot before end of name.
      send_item(8'h77, 1'b0);
      send_item(DOT_CHAR, 1'b0);
      send_item(DOT_CHAR, 1'b1);
      send_item(DOT_CHAR, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(8'h2D, 1'b0);
      send_item(8'h2F, 1'b0);
      send_item(8'hFF, 1'b1);
      send_item(8'h78, 1'b0);
      send_item(DOT_CHAR, 1'b0);
      send_item(8'h00, 1'b1);
      send_item(8'h61, 1'b0);
      send_item(8'h62, 1'b0);
      send_item(8'h63, 1'b0);
      send_item(8'h00, 1'b1);
      wait_for_drain();

      // Pressure: the output holds off for a long stretch while an overflowing
      // label, an exactly full label, one just under full and a few short ones are offered.
      holds_wanted <= holds_wanted + 1;
      send_label(LABEL_MAX_DEF + 3, 1'b1);
      send_label(LABEL_MAX_DEF, 1'b0);
      send_label(LABEL_MAX_DEF - 1, 1'b1);
      for (int i = 0; i < 6; i++) begin
         send_label($urandom_range(0, 5), 1'($urandom_range(0, 1)));
      end
      wait_for_drain();

      // Random host names; the sender pauses for a full drain halfway through.
      random_start = items_sent;
      half_done    = 0;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         send_label(label_length(), $urandom_range(0, 99) < 30);
         if (!half_done && items_sent - random_start >= RANDOM_ITEMS / 2) begin
            half_done = 1;
            wait_for_drain();
         end
      end

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d name items, %0d encoded bytes over %0d labels,",
               items_sent, bytes_checked, labels_closed,
               " %0d of them overflowed.", overflowed_labels);
      $display("Mismatches: %0d; bytes still expected: %0d.", mismatch_count, bytes_pending);
      if (mismatch_count == 0 && bytes_pending == 0) begin
         $display("dns_name_label_encoder_unit regression: pass");
      end else begin
         $display("dns_name_label_encoder_unit regression: fail");
      end
      $finish;
   end

endmodule
